FILE: src/hqf_pkg.sv
`timescale 1ns / 1ps
package hqf_pkg;
   localparam int LEVEL_COUNT = 7;
   localparam int LVL_W = 3;
   localparam logic [LVL_W-1:0] DONE_CODE = 3'd7;
   localparam logic [32:0] CUM_MAX = 33'h1_FFFF_FFFF;
   localparam logic [31:0] LEVEL_RESET [LEVEL_COUNT] = '{
      32'd6442451, 32'd97710506, 32'd681418036, 32'd2147483648,
      32'd3613549260, 32'd4197256790, 32'd4288524845};
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   typedef enum logic [1:0] {JOB_INTERP, JOB_PLAIN} job_kind_type;

   // one job for the back end: one result, maybe needing interpolation
   typedef struct packed {
      job_kind_type     kind;
      logic [LVL_W-1:0] code;
      logic [31:0]      pos_a;
      logic [31:0]      pos_b;
      logic [31:0]      mass_a;
      logic [31:0]      mass_b;
      logic [31:0]      frac_r;
      logic [31:0]      frac_m;
      logic             found;
      logic             last;
   } job_type;

   typedef enum logic [1:0] {BE_IDLE, BE_MUL, BE_DIV, BE_OUT} be_state_type;
   typedef enum logic [1:0] {FE_TAKE, FE_SCAN, FE_MISS, FE_DONE} fe_state_type;
endpackage

FILE: src/hqf_front.sv
`timescale 1ns / 1ps
module hqf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,
   input  logic                 req_tlast,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output logic                 job_valid,
   input  logic                 job_ready,
   output hqf_pkg::job_type     job
);
   import hqf_pkg::*;

   logic [31:0] level_ff [LEVEL_COUNT];
   logic [32:0] cum_ff, cum_in, prev_cum_ff, prev_cum_in;
   logic [31:0] prev_pos_ff, prev_pos_in, prev_mass_ff, prev_mass_in;
   logic [31:0] first_ff, first_in, pos_ff, pos_in, mass_ff, mass_in;
   logic seen_ff, seen_in, was_seen_ff, was_seen_in, last_ff, last_in;
   logic [LEVEL_COUNT-1:0] found_ff, found_in;
   logic [LVL_W-1:0] k_ff, k_in;
   fe_state_type state_ff, state_in;
   logic [33:0] sum_w;
   logic [32:0] r_w;
   logic [31:0] lv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVEL_COUNT; i++) level_ff[i] <= LEVEL_RESET[i];
      end else if (csr_we && csr_index < LVL_W'(LEVEL_COUNT)) begin
         level_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_TAKE; cum_ff <= '0; seen_ff <= 1'b0; found_ff <= '0;
         prev_pos_ff <= '0; prev_mass_ff <= '0; first_ff <= '0;
      end else begin
         state_ff <= state_in; cum_ff <= cum_in; seen_ff <= seen_in;
         found_ff <= found_in; prev_pos_ff <= prev_pos_in;
         prev_mass_ff <= prev_mass_in; first_ff <= first_in;
      end
      prev_cum_ff <= prev_cum_in; pos_ff <= pos_in; mass_ff <= mass_in;
      was_seen_ff <= was_seen_in; last_ff <= last_in; k_ff <= k_in;
   end

   assign lv = level_ff[k_ff];

   always_comb begin
      state_in = state_ff; cum_in = cum_ff; seen_in = seen_ff;
      found_in = found_ff; prev_pos_in = prev_pos_ff;
      prev_mass_in = prev_mass_ff; first_in = first_ff;
      prev_cum_in = prev_cum_ff; pos_in = pos_ff; mass_in = mass_ff;
      was_seen_in = was_seen_ff; last_in = last_ff; k_in = k_ff;
      req_tready = 1'b0; job_valid = 1'b0; job = '0;
      sum_w = {1'b0, cum_ff} + 34'(req_tdata[63:32]);
      r_w = ({1'b0, lv} > prev_cum_ff) ? 33'({1'b0, lv} - prev_cum_ff) : '0;
      if (r_w > 33'(mass_ff)) r_w = 33'(mass_ff);
      job.code = k_ff;
      job.pos_a = first_ff;
      unique case (state_ff)
         FE_TAKE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               prev_cum_in = cum_ff;
               cum_in = sum_w[33] ? CUM_MAX : sum_w[32:0];
               pos_in = req_tdata[31:0]; mass_in = req_tdata[63:32];
               last_in = req_tlast; was_seen_in = seen_ff;
               if (!seen_ff) first_in = req_tdata[31:0];
               k_in = '0; state_in = FE_SCAN;
            end
         end
         FE_SCAN: begin
            // one level per cycle while the queue takes jobs; a crossing becomes a queued job
            job.kind = was_seen_ff ? JOB_INTERP : JOB_PLAIN;
            job.pos_a = was_seen_ff ? prev_pos_ff : pos_ff;
            job.pos_b = pos_ff;
            job.mass_a = was_seen_ff ? prev_mass_ff : mass_ff;
            job.mass_b = mass_ff;
            job.frac_r = r_w[31:0]; job.frac_m = mass_ff; job.found = 1'b1;
            if (!found_ff[k_ff] && cum_ff >= {1'b0, lv}) begin
               job_valid = 1'b1;
               if (job_ready) found_in[k_ff] = 1'b1;
            end
            if (!job_valid || job_ready) begin
               if (k_ff == LVL_W'(LEVEL_COUNT - 1)) begin
                  prev_pos_in = pos_ff; prev_mass_in = mass_ff; seen_in = 1'b1;
                  k_in = '0;
                  state_in = last_ff ? FE_MISS : FE_TAKE;
               end else k_in = k_ff + 1'b1;
            end
         end
         FE_MISS: begin
            job.kind = JOB_PLAIN;
            if (!found_ff[k_ff]) job_valid = 1'b1;
            if (!job_valid || job_ready) begin
               if (k_ff == LVL_W'(LEVEL_COUNT - 1)) state_in = FE_DONE;
               else k_in = k_ff + 1'b1;
            end
         end
         FE_DONE: begin
            job.kind = JOB_PLAIN; job.code = DONE_CODE; job.last = 1'b1;
            job.mass_a = cum_ff[32] ? 32'hFFFF_FFFF : cum_ff[31:0];
            job_valid = 1'b1;
            if (job_ready) begin
               cum_in = '0; seen_in = 1'b0; found_in = '0; state_in = FE_TAKE;
            end
         end
         default: state_in = FE_TAKE;
      endcase
   end

   a_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == FE_SCAN) else $error("take");
   a_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == FE_DONE && job_ready |=> found_ff == '0) else $error("clr");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      $past(cum_ff) > cum_ff |-> cum_ff == '0) else $error("sat");
endmodule

FILE: src/hqf_queue.sv
`timescale 1ns / 1ps
module hqf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  hqf_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output hqf_pkg::job_type out_job
);
   import hqf_pkg::*;
   job_type mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0] cnt_ff, cnt_in;

   assign in_ready = cnt_ff != (QPTR_W+1)'(QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_job = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff; rd_in = rd_ff; cnt_in = cnt_ff;
      if (in_valid && in_ready) wr_in = wr_ff + 1'b1;
      if (out_valid && out_ready) rd_in = rd_ff + 1'b1;
      if ((in_valid && in_ready) && !(out_valid && out_ready)) cnt_in = cnt_ff + 1'b1;
      else if (!(in_valid && in_ready) && (out_valid && out_ready)) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (in_valid && in_ready) mem_ff[wr_ff] <= in_job;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_W+1)'(QDEPTH)) else $error("cnt");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> wr_ff == rd_ff) else $error("ptr");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("hold");
endmodule

FILE: src/hqf_back.sv
`timescale 1ns / 1ps
module hqf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  hqf_pkg::job_type job,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [71:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);
   import hqf_pkg::*;
   be_state_type state_ff, state_in;
   job_type j_ff, j_in;
   logic [63:0] np_ff, np_in, nd_ff, nd_in;   // numerators
   logic [31:0] qp_ff, qp_in, qd_ff, qd_in;
   logic [32:0] rp_ff, rp_in, rd_ff, rd_in;
   logic [5:0]  bit_ff, bit_in;
   logic        negp_ff, negp_in, negd_ff, negd_in;
   logic [31:0] pos_ff, pos_in, den_ff, den_in;
   logic [32:0] dp, trp, trd;
   logic [31:0] md;
   logic signed [32:0] dsp;

   assign dsp = 33'(signed'(j_ff.pos_b)) - 33'(signed'(j_ff.pos_a));

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BE_IDLE;
      else state_ff <= state_in;
      j_ff <= j_in; np_ff <= np_in; nd_ff <= nd_in; qp_ff <= qp_in;
      qd_ff <= qd_in; rp_ff <= rp_in; rd_ff <= rd_in; bit_ff <= bit_in;
      negp_ff <= negp_in; negd_ff <= negd_in; pos_ff <= pos_in; den_ff <= den_in;
   end

   always_comb begin
      state_in = state_ff; j_in = j_ff; np_in = np_ff; nd_in = nd_ff;
      qp_in = qp_ff; qd_in = qd_ff; rp_in = rp_ff; rd_in = rd_ff;
      bit_in = bit_ff; negp_in = negp_ff; negd_in = negd_ff;
      pos_in = pos_ff; den_in = den_ff; job_ready = 1'b0;
      dp = dsp[32] ? 33'(-dsp) : dsp;
      md = (j_ff.mass_b >= j_ff.mass_a) ? j_ff.mass_b - j_ff.mass_a
                                         : j_ff.mass_a - j_ff.mass_b;
      trp = {rp_ff[31:0], np_ff[6'd63 - bit_ff]};
      trd = {rd_ff[31:0], nd_ff[6'd63 - bit_ff]};
      unique case (state_ff)
         BE_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               j_in = job;
               pos_in = job.pos_a; den_in = job.mass_a;
               state_in = (job.kind == JOB_INTERP && job.frac_m != '0) ? BE_MUL : BE_OUT;
            end
         end
         BE_MUL: begin
            // magnitude products; difference magnitude fits 32 bits x r < 2^64
            np_in = dp[31:0] * j_ff.frac_r; nd_in = md * j_ff.frac_r;
            negp_in = dsp[32]; negd_in = j_ff.mass_b < j_ff.mass_a;
            rp_in = '0; rd_in = '0; bit_in = '0; state_in = BE_DIV;
         end
         BE_DIV: begin
            // restoring division, one quotient bit per cycle, low 32 kept
            if (trp >= {1'b0, j_ff.frac_m}) begin
               rp_in = trp - {1'b0, j_ff.frac_m}; qp_in = {qp_ff[30:0], 1'b1};
            end else begin
               rp_in = trp; qp_in = {qp_ff[30:0], 1'b0};
            end
            if (trd >= {1'b0, j_ff.frac_m}) begin
               rd_in = trd - {1'b0, j_ff.frac_m}; qd_in = {qd_ff[30:0], 1'b1};
            end else begin
               rd_in = trd; qd_in = {qd_ff[30:0], 1'b0};
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 6'd63) begin
               pos_in = negp_ff ? j_ff.pos_a - qp_in : j_ff.pos_a + qp_in;
               den_in = negd_ff ? j_ff.mass_a - qd_in : j_ff.mass_a + qd_in;
               state_in = BE_OUT;
            end
         end
         BE_OUT: if (rsp_tready) state_in = BE_IDLE;
         default: state_in = BE_IDLE;
      endcase
   end

   assign rsp_tvalid = state_ff == BE_OUT;
   assign rsp_tdata = {5'd0, den_ff, pos_ff, j_ff.code};
   assign rsp_tuser = j_ff.found;
   assign rsp_tlast = j_ff.last;

   a_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("o");
   a_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == BE_DIV |-> rp_ff < {1'b0, j_ff.frac_m}) else $error("d");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      job_ready |-> !rsp_tvalid) else $error("r");
endmodule

FILE: src/histogram_quantile_finder.sv
`timescale 1ns / 1ps
// histogram quantile finder: bins stream in on req_ (position, mass, tlast on
// the final bin); the front end takes a bin, then checks the seven levels
// one per cycle while the queue takes jobs, queuing each crossing,
// each missing level and the done result as a job in a four-deep queue.
// the back end produces one result per job: interpolated ones take one
// multiply, then a 64-step bit-serial divider, so a crossing holds back the
// front end only once the queue fills. levels are written on csr_; the user
// must write them only while the block is idle; the block does not enforce this.
module histogram_quantile_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // bin_position, bin_mass
   input  logic        req_tlast,   // last_bin
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // level_code, crossing_position, crossing_density
   output logic        rsp_tlast,   // last
   output logic        rsp_tuser,   // found
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import hqf_pkg::*;
   job_type fj, bj;
   logic fv, fr, bv, br;

   // front: accumulate and classify each transaction
   hqf_front u_front (.clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .req_tlast, .csr_we, .csr_index, .csr_wdata,
      .job_valid(fv), .job_ready(fr), .job(fj));
   // decoupling queue
   hqf_queue u_queue (.clock, .reset, .in_valid(fv), .in_ready(fr), .in_job(fj),
      .out_valid(bv), .out_ready(br), .out_job(bj));
   // back: interpolation and result register
   hqf_back u_back (.clock, .reset, .job_valid(bv), .job_ready(br), .job(bj),
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser);
endmodule
